// File: hdl/ckg_pkg.sv
// ckg_pkg: shared types and constants for the cell elevation kalman gate
// cell entry layout, controller states, result codes, register indexes
// no dependencies
`timescale 1ns / 1ps
package ckg_pkg;

  localparam int GRID_X_DEF = 256;
  localparam int GRID_Y_DEF = 256;

  // divider geometry: 65 bit dividend, 33 bit divisor, 32 bit quotient
  localparam int NUM_W = 65;
  localparam int DEN_W = 33;
  localparam int QUO_W = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELIABLE_COUNT    = 3'd0,
    CFG_REJECT_LIMIT      = 3'd1,
    CFG_INITIAL_VARIANCE  = 3'd2,
    CFG_MEASUREMENT_NOISE = 3'd3,
    CFG_PROCESS_NOISE     = 3'd4
  } cfg_idx_t;

  localparam logic [15:0] RELIABLE_COUNT_RST    = 16'd15;
  localparam logic [3:0]  REJECT_LIMIT_RST      = 4'd3;
  localparam logic [31:0] INITIAL_VARIANCE_RST  = 32'd1677722;
  localparam logic [31:0] MEASUREMENT_NOISE_RST = 32'd167772;
  localparam logic [31:0] PROCESS_NOISE_RST     = 32'd1678;

  typedef enum logic [1:0] {
    OUT_SEEDED   = 2'd0,
    OUT_REJECTED = 2'd1,
    OUT_ANCHORED = 2'd2,
    OUT_ACCEPTED = 2'd3
  } outcome_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_GATE,
    ST_CMP,
    ST_MUL_VD,
    ST_MUL_VR,
    ST_DSTART,
    ST_DIV,
    ST_JMP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic        known;
    logic [15:0] count;
    logic [3:0]  streak;
    logic [31:0] mean;
    logic [31:0] variance;
  } cell_entry_t;

  localparam int ENTRY_W = $bits(cell_entry_t);

endpackage

// File: hdl/cell_elevation_kalman_gate.sv
// cell_elevation_kalman_gate: per-cell scalar kalman height filter with 3 sigma gate
// depends on ckg_pkg, ckg_ram (cell state store), ckg_div (gain divisions)
//
//   channel  ports                                        direction  request
//   in       in_valid/in_ready, cell_x, cell_y, elevation  input      one measurement
//   out      out_valid/out_ready, outcome, mark_changed,   output     one result per request
//            mean_out, count_out
//   cfg      cfg_we, cfg_index, cfg_data                   input      register write
//
// after reset a clearing pass writes every cell entry (GRID_X*GRID_Y,
// 65536 by default) with in_ready low; cfg writes are taken meanwhile
// one request at a time: a seed goes load, fin; a gate reject or re-anchor goes
// load, gate, cmp, fin; an accepted update adds two multiplies and the radix-2 division
// a finished result waits in the output register; the next request is taken
// while it waits, and its write-back holds until the output register frees
`timescale 1ns / 1ps
module cell_elevation_kalman_gate #(
  parameter int GRID_X = ckg_pkg::GRID_X_DEF,
  parameter int GRID_Y = ckg_pkg::GRID_Y_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_cell_x,
  input  logic [7:0]                    in_cell_y,
  input  logic signed [31:0]            in_elevation,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_outcome,
  output logic                          out_mark_changed,
  output logic signed [31:0]            out_mean_out,
  output logic [15:0]                   out_count_out,
  input  logic                          cfg_we,
  input  logic [ckg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ckg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ckg_pkg::*;

  localparam int DEPTH = GRID_X * GRID_Y;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);

  // configuration registers
  logic [15:0] rel_cnt_r;
  logic [3:0]  rej_lim_r;
  logic [31:0] init_var_r;
  logic [31:0] meas_noise_r;
  logic [31:0] proc_noise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_cnt_r    <= RELIABLE_COUNT_RST;
      rej_lim_r    <= REJECT_LIMIT_RST;
      init_var_r   <= INITIAL_VARIANCE_RST;
      meas_noise_r <= MEASUREMENT_NOISE_RST;
      proc_noise_r <= PROCESS_NOISE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RELIABLE_COUNT:    rel_cnt_r    <= cfg_data[15:0];
        CFG_REJECT_LIMIT:      rej_lim_r    <= cfg_data[3:0];
        CFG_INITIAL_VARIANCE:  init_var_r   <= cfg_data;
        CFG_MEASUREMENT_NOISE: meas_noise_r <= cfg_data;
        CFG_PROCESS_NOISE:     proc_noise_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // coordinate wrap: constant modulo tables, indexed by the 8 bit coordinate
  logic [XW-1:0] xmod [256];
  logic [YW-1:0] ymod [256];
  for (genvar i = 0; i < 256; i++) begin : g_wrap
    assign xmod[i] = XW'(i % GRID_X);
    assign ymod[i] = YW'(i % GRID_Y);
  end

  logic [AW-1:0] in_addr;
  assign in_addr = AW'(AW'(ymod[in_cell_y]) * AW'(GRID_X)) + AW'(xmod[in_cell_x]);

  // controller
  state_t state_r, state_nxt;
  logic   in_fire, out_free, fin_go, div_start, div_done_a, div_done_v;
  logic   out_valid_r;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign fin_go   = (state_r == ST_FIN) && out_free;

  // per-request registers
  logic [AW-1:0]        addr_r;
  logic signed [31:0]   z_r;
  cell_entry_t          ent_r;
  logic [31:0]          v_r;
  logic [DEN_W-1:0]     s_r;
  logic [32:0]          dmag_r;
  logic                 dneg_r;
  outcome_t             outcome_r;
  logic [NUM_W-1:0]     num_d_r;
  logic [63:0]          prod_r;
  logic [AW-1:0]        clr_cnt_r;

  // cell store
  logic [ENTRY_W-1:0] rd_data;
  cell_entry_t        rd_ent;
  cell_entry_t        wr_ent;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;

  assign rd_ent    = cell_entry_t'(rd_data);
  assign ram_we    = (state_r == ST_CLEAR) || fin_go;
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : addr_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : ENTRY_W'(wr_ent);

  ckg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // gate decision inputs, valid in ST_CMP
  logic [36:0] s9;
  logic        gate_reject;
  logic [4:0]  streak_inc;
  assign s9          = 37'(s_r) + {s_r, 3'b000};
  assign gate_reject = (|dmag_r[32:23]) || (prod_r > 64'({s9, 8'h00}));
  assign streak_inc  = 5'(ent_r.streak) + 5'd1;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_CLEAR:  if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = ST_LOAD;
      end
      ST_LOAD:   state_nxt = rd_ent.known ? ST_GATE : ST_FIN;
      ST_GATE:   state_nxt = ST_CMP;
      ST_CMP:    state_nxt = gate_reject ? ST_FIN : ST_MUL_VD;
      ST_MUL_VD: state_nxt = ST_MUL_VR;
      ST_MUL_VR: state_nxt = ST_DSTART;
      ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV:    if (div_done_a) state_nxt = ST_JMP;
      ST_JMP:    state_nxt = ST_FIN;
      ST_FIN:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // dividers: delta magnitude and posterior variance, run side by side
  logic [NUM_W-1:0] num_v;
  logic [QUO_W-1:0] q_d, q_v;
  assign num_v = NUM_W'(prod_r) + NUM_W'(s_r >> 1);

  ckg_div u_div_delta (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_d_r),
    .den   (s_r),
    .done  (div_done_a),
    .quo   (q_d)
  );

  ckg_div u_div_var (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_v),
    .den   (s_r),
    .done  (div_done_v),
    .quo   (q_v)
  );

  // zero S means zero gain
  logic        s_zero;
  logic [31:0] amag;
  assign s_zero = (s_r == '0);
  assign amag   = s_zero ? 32'd0 : q_d;

  // shared multiplier, one product per cycle, always registered
  // delta squared is kept alive through ST_FIN while the result stalls
  logic [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_GATE: begin
        mul_a = 32'(dmag_r[22:0]);
        mul_b = 32'(dmag_r[22:0]);
      end
      ST_MUL_VD: begin
        mul_a = v_r;
        mul_b = dmag_r[31:0];
      end
      ST_MUL_VR: begin
        mul_a = v_r;
        mul_b = meas_noise_r;
      end
      ST_JMP, ST_FIN: begin
        mul_a = amag;
        mul_b = amag;
      end
      default: ;
    endcase
  end

  // prior: v = sat(var + Q), s = v + R, d = z - mean
  logic [32:0] v_sum;
  logic [31:0] v_sat;
  logic [32:0] d_full;
  assign v_sum  = 33'(rd_ent.variance) + 33'(proc_noise_r);
  assign v_sat  = v_sum[32] ? 32'hFFFF_FFFF : v_sum[31:0];
  assign d_full = {z_r[31], z_r} - {rd_ent.mean[31], rd_ent.mean};

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    if (in_fire) begin
      addr_r <= in_addr;
      z_r    <= in_elevation;
    end
    if (state_r == ST_LOAD) begin
      ent_r     <= rd_ent;
      v_r       <= v_sat;
      s_r       <= 33'(v_sat) + 33'(meas_noise_r);
      dneg_r    <= d_full[32];
      dmag_r    <= d_full[32] ? 33'(-d_full) : d_full;
      outcome_r <= OUT_SEEDED;
    end
    if (state_r == ST_CMP) begin
      if (!gate_reject) begin
        outcome_r <= OUT_ACCEPTED;
      end else if (streak_inc < 5'(rej_lim_r)) begin
        outcome_r <= OUT_REJECTED;
      end else begin
        outcome_r <= OUT_ANCHORED;
      end
    end
    if (state_r == ST_MUL_VR) begin
      num_d_r <= NUM_W'(prod_r) + NUM_W'(s_r >> 1);
    end
  end

  // write-back entry and result
  logic [32:0] delta;
  logic [32:0] nmean;
  logic [15:0] count_inc;
  logic [43:0] v9;
  logic        jump, maturing, mark;
  assign delta     = dneg_r ? 33'(-{1'b0, amag}) : {1'b0, amag};
  assign nmean     = {ent_r.mean[31], ent_r.mean} + delta;
  assign count_inc = (ent_r.count == 16'hFFFF) ? ent_r.count : ent_r.count + 16'd1;
  assign v9        = {(36'(v_r) + {v_r, 3'b000}), 8'h00};
  assign jump      = (|amag[31:23]) || (prod_r > 64'(v9));
  assign maturing  = ent_r.count <= rel_cnt_r;

  always_comb begin
    wr_ent = ent_r;
    mark   = 1'b0;
    case (outcome_r)
      OUT_SEEDED, OUT_ANCHORED: begin
        wr_ent.known    = 1'b1;
        wr_ent.mean     = z_r;
        wr_ent.variance = init_var_r;
        wr_ent.count    = 16'd1;
        wr_ent.streak   = 4'd0;
        mark            = 1'b1;
      end
      OUT_REJECTED: begin
        wr_ent.streak = streak_inc[3:0];
      end
      OUT_ACCEPTED: begin
        wr_ent.mean     = nmean[31:0];
        wr_ent.variance = s_zero ? 32'd0 : q_v;
        wr_ent.count    = count_inc;
        wr_ent.streak   = 4'd0;
        mark            = maturing || jump;
      end
      default: ;
    endcase
  end

  // output register
  logic [1:0]  outcome_o_r;
  logic        mark_o_r;
  logic [31:0] mean_o_r;
  logic [15:0] count_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      outcome_o_r <= outcome_r;
      mark_o_r    <= mark;
      mean_o_r    <= wr_ent.mean;
      count_o_r   <= wr_ent.count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = outcome_o_r;
  assign out_mark_changed = mark_o_r;
  assign out_mean_out     = mean_o_r;
  assign out_count_out    = count_o_r;

  // checks
  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_LOAD)
    else $error("accepted request did not move to load");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ready)
    else $error("request taken during clearing pass");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_FIN)
    else $error("result raised outside write-back");

  a_div_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    div_done_a |-> (state_r == ST_DIV) && div_done_v)
    else $error("divider finish out of step");

endmodule

// File: hdl/ckg_ram.sv
// ckg_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
module ckg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/ckg_div.sv
// ckg_div: radix-2 restoring divider, one quotient bit per cycle
// depends on ckg_pkg for operand widths
`timescale 1ns / 1ps
module ckg_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ckg_pkg::NUM_W-1:0] num,
  input  logic [ckg_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [ckg_pkg::QUO_W-1:0] quo
);
  import ckg_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W-1:0] rem_nxt;
  logic [QUO_W-1:0] quo_nxt;

  // upper dividend bits sit below the divisor whenever the quotient fits
  always_comb begin
    trial   = {rem_r, quo_r[QUO_W-1]};
    fits    = trial >= {1'b0, den};
    rem_nxt = fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    quo_nxt = {quo_r[QUO_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(QUO_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NUM_W-1:QUO_W];
      quo_r <= num[QUO_W-1:0];
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: tb/tb_cell_elevation_kalman_gate.sv
// tb_cell_elevation_kalman_gate: self-checking bench for the per-cell kalman height gate
// predicts every result from its own model of the cell store and registers
// depends on ckg_pkg and cell_elevation_kalman_gate
`timescale 1ns / 1ps
module tb_cell_elevation_kalman_gate;
  import ckg_pkg::*;

  typedef struct packed {
    logic [7:0]         x;
    logic [7:0]         y;
    logic signed [31:0] z;
  } meas_t;

  typedef struct packed {
    outcome_t           outcome;
    logic               mark;
    logic signed [31:0] mean;
    logic [15:0]        count;
  } est_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_cell_x = '0;
  logic [7:0] in_cell_y = '0;
  logic signed [31:0] in_elevation = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_outcome;
  logic out_mark_changed;
  logic signed [31:0] out_mean_out;
  logic [15:0] out_count_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cell_elevation_kalman_gate dut (.*);

  always #5 clk = ~clk;

  // predictor state: registers and per-cell filter store
  logic [15:0] p_reliable;
  logic [3:0]  p_rej_limit;
  logic [31:0] p_init_var, p_meas_noise, p_proc_noise;
  logic        p_known [65536];
  logic [31:0] p_mean [65536];
  logic [31:0] p_var [65536];
  logic [15:0] p_count [65536];
  logic [3:0]  p_streak [65536];

  meas_t pending_meas[$];
  est_t  expected_est[$];
  int    send_idle_pct = 0, recv_stall_pct = 0;
  int    errors = 0, n_results = 0;
  int    n_outcome [4];

  // tracks whether the current request was taken at the last rising edge
  logic in_ready_seen = 1'b0;

  function automatic void queue_meas(meas_t m);
    pending_meas.insert(pending_meas.size(), m);
  endfunction

  // kalman step for one measurement, updates the model store
  function automatic est_t filter_step(meas_t m);
    logic [15:0] c;
    logic signed [33:0] d;
    logic [33:0] dmag, s, v;
    logic [67:0] lhs, rhs, num, q, amag, nvar;
    logic signed [34:0] delta;
    logic signed [34:0] nmean;
    logic mature, jump;
    est_t r;
    c = {m.y, m.x};
    r.mark = 1'b0;
    if (!p_known[c]) begin
      p_known[c] = 1'b1; p_mean[c] = m.z; p_var[c] = p_init_var;
      p_count[c] = 16'd1; p_streak[c] = '0;
      r.outcome = OUT_SEEDED; r.mark = 1'b1;
    end else begin
      v = {2'b0, p_var[c]} + {2'b0, p_proc_noise};
      if (v > 34'hFFFF_FFFF) v = 34'hFFFF_FFFF;
      s = v + {2'b0, p_meas_noise};
      d = $signed({{2{m.z[31]}}, m.z}) - $signed({{2{p_mean[c][31]}}, p_mean[c]});
      dmag = d[33] ? -d : d;
      lhs = {34'b0, dmag} * {34'b0, dmag};
      rhs = 68'd9 * {34'b0, s} * 68'd256;
      if (lhs > rhs) begin
        if ({1'b0, p_streak[c]} + 5'd1 < {1'b0, p_rej_limit}) begin
          p_streak[c] = p_streak[c] + 4'd1;
          r.outcome = OUT_REJECTED;
        end else begin
          p_mean[c] = m.z; p_var[c] = p_init_var; p_count[c] = 16'd1;
          p_streak[c] = '0; r.outcome = OUT_ANCHORED; r.mark = 1'b1;
        end
      end else begin
        // zero innovation variance gives zero gain
        if (s == 0) begin
          q = '0; nvar = '0;
        end else begin
          num = {34'b0, v} * {34'b0, dmag};
          q = (num + {34'b0, s} / 2) / {34'b0, s};
          nvar = ({34'b0, v} * {36'b0, p_meas_noise} + {34'b0, s} / 2) / {34'b0, s};
        end
        delta = d[33] ? -$signed({1'b0, q[33:0]}) : $signed({1'b0, q[33:0]});
        amag = q;
        mature = p_count[c] <= p_reliable;
        jump = amag * amag > 68'd9 * {34'b0, v} * 68'd256;
        nmean = $signed({{3{p_mean[c][31]}}, p_mean[c]}) + delta;
        p_streak[c] = '0; p_mean[c] = nmean[31:0]; p_var[c] = nvar[31:0];
        if (p_count[c] != 16'hFFFF) p_count[c] = p_count[c] + 16'd1;
        r.outcome = OUT_ACCEPTED; r.mark = mature | jump;
      end
    end
    r.mean = p_mean[c];
    r.count = p_count[c];
    return r;
  endfunction

  // driver: presents pending requests, predicts at acceptance
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      expected_est.insert(expected_est.size(), filter_step(pending_meas.pop_front()));
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_ready_seen)) begin
      if (pending_meas.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid     <= 1'b1;
        in_cell_x    <= pending_meas[0].x;
        in_cell_y    <= pending_meas[0].y;
        in_elevation <= pending_meas[0].z;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) in_ready_seen <= in_valid && in_ready;

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    est_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_est.size() == 0) begin
        errors++;
        $display("%0t: unexpected result outcome %0d mean %0d count %0d", $time,
                 out_outcome, out_mean_out, out_count_out);
      end else begin
        e = expected_est.pop_front();
        n_outcome[e.outcome]++;
        if (out_outcome !== e.outcome) begin
          errors++;
          $display("%0t: outcome expected %0d actual %0d", $time, e.outcome, out_outcome);
        end
        if (out_mark_changed !== e.mark) begin
          errors++;
          $display("%0t: mark_changed expected %0d actual %0d", $time, e.mark,
                   out_mark_changed);
        end
        if (out_mean_out !== e.mean) begin
          errors++;
          $display("%0t: mean_out expected %0d actual %0d", $time, e.mean, out_mean_out);
        end
        if (out_count_out !== e.count) begin
          errors++;
          $display("%0t: count_out expected %0d actual %0d", $time, e.count, out_count_out);
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RELIABLE_COUNT:    p_reliable   = val[15:0];
      CFG_REJECT_LIMIT:      p_rej_limit  = val[3:0];
      CFG_INITIAL_VARIANCE:  p_init_var   = val;
      CFG_MEASUREMENT_NOISE: p_meas_noise = val;
      CFG_PROCESS_NOISE:     p_proc_noise = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_meas.size() != 0 || expected_est.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);
  endtask

  function automatic meas_t rand_meas(int hot);
    meas_t m;
    // most requests hit a few cells near a shared height so updates mature
    m.x = hot ? 8'($urandom_range(7)) : 8'($urandom);
    m.y = hot ? 8'($urandom_range(3)) : 8'($urandom);
    case ($urandom_range(9))
      0:       m.z = $urandom;
      1:       m.z = 32'sd65536 * 300 + $signed(32'($urandom_range(2000000))) - 1000000;
      default: m.z = 32'sd65536 * 300 + $signed(32'($urandom_range(20000))) - 10000;
    endcase
    return m;
  endfunction

  task automatic run_phase(int idle, int stall, int n);
    send_idle_pct = idle; recv_stall_pct = stall;
    for (int i = 0; i < n; i++) queue_meas(rand_meas($urandom_range(9) < 8));
    drain();
  endtask

  initial begin
    p_reliable = RELIABLE_COUNT_RST; p_rej_limit = REJECT_LIMIT_RST;
    p_init_var = INITIAL_VARIANCE_RST; p_meas_noise = MEASUREMENT_NOISE_RST;
    p_proc_noise = PROCESS_NOISE_RST;
    for (int i = 0; i < 65536; i++) begin
      p_known[i] = 0; p_count[i] = 0; p_streak[i] = 0; p_mean[i] = 0; p_var[i] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: seed extremes, accept, gate rejects up to re-anchor
    queue_meas('{8'd0, 8'd0, 32'sh7FFF_FFFF});
    queue_meas('{8'd255, 8'd255, 32'sh8000_0000});
    queue_meas('{8'd0, 8'd0, 32'sh8000_0000});
    queue_meas('{8'd0, 8'd0, 32'sh8000_0000});
    queue_meas('{8'd0, 8'd0, 32'sh8000_0000});
    queue_meas('{8'd255, 8'd255, 32'sh8000_0000});
    queue_meas('{8'd255, 8'd255, 32'sh8000_1000});
    queue_meas('{8'd170, 8'd85, 32'sh5555_5555});
    queue_meas('{8'd85, 8'd170, 32'shAAAA_AAAA});
    drain();

    // zero noise: zero gain special case, then reject limit zero, extreme variance
    write_reg(CFG_PROCESS_NOISE, 32'd0);
    write_reg(CFG_MEASUREMENT_NOISE, 32'd0);
    write_reg(CFG_INITIAL_VARIANCE, 32'd0);
    write_reg(CFG_REJECT_LIMIT, 4'd0);
    write_reg(CFG_RELIABLE_COUNT, 16'd0);
    for (int i = 0; i < 4; i++) queue_meas('{8'd9, 8'd9, 32'sd100});
    queue_meas('{8'd9, 8'd9, 32'sd101});
    drain();
    write_reg(CFG_PROCESS_NOISE, 32'hFFFF_FFFF);
    write_reg(CFG_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
    write_reg(CFG_INITIAL_VARIANCE, 32'hFFFF_FFFF);
    write_reg(CFG_REJECT_LIMIT, 4'd15);
    write_reg(CFG_RELIABLE_COUNT, 16'hFFFF);
    for (int i = 0; i < 6; i++) queue_meas('{8'd12, 8'd3, $signed($urandom)});
    drain();

    // random phases over a spread of register settings, input idling and output stalls
    write_reg(CFG_PROCESS_NOISE, PROCESS_NOISE_RST);
    write_reg(CFG_MEASUREMENT_NOISE, MEASUREMENT_NOISE_RST);
    write_reg(CFG_INITIAL_VARIANCE, INITIAL_VARIANCE_RST);
    write_reg(CFG_REJECT_LIMIT, REJECT_LIMIT_RST);
    write_reg(CFG_RELIABLE_COUNT, 16'd15);
    run_phase(0, 0, 200);
    write_reg(CFG_REJECT_LIMIT, 4'd1);
    write_reg(CFG_RELIABLE_COUNT, 16'd4);
    write_reg(CFG_PROCESS_NOISE, $urandom_range(100000));
    run_phase(63, 0, 200);
    write_reg(CFG_REJECT_LIMIT, 4'd15);
    write_reg(CFG_MEASUREMENT_NOISE, $urandom);
    run_phase(0, 63, 200);
    write_reg(CFG_REJECT_LIMIT, 4'd2);
    write_reg(CFG_INITIAL_VARIANCE, $urandom_range(50000000));
    run_phase(13, 13, 200);

    $display("covered %0d results: %0d seeded, %0d rejected, %0d re-anchored, %0d accepted",
             n_results, n_outcome[0], n_outcome[1], n_outcome[2], n_outcome[3]);
    if (errors == 0) begin
      $display("tb_cell_elevation_kalman_gate passed");
    end else begin
      $display("tb_cell_elevation_kalman_gate failed");
    end
    $finish;
  end

  // clearing pass plus worst case accepted updates with heavy stalls
  initial begin
    #20ms;
    $display("tb_cell_elevation_kalman_gate failed");
    $finish;
  end

endmodule
